/* src/cra_pkg.sv */
// Shared types, command codes and widths for the cyclotomic ring ALU.
package cra_pkg;

   localparam int CoordWidth = 12;
   localparam int ProdWidth  = 2 * CoordWidth;
   localparam int WordWidth  = 32;
   localparam int QuartWidth = 28;
   localparam int NormWidth  = 52;
   localparam int NumCoords  = 4;

   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_SUB     = 3'd1;
   localparam logic [2:0] CMD_MUL     = 3'd2;
   localparam logic [2:0] CMD_SCALE   = 3'd3;
   localparam logic [2:0] CMD_CONJ    = 3'd4;
   localparam logic [2:0] CMD_CONJ_NM = 3'd5;
   localparam logic [2:0] CMD_NORM    = 3'd6;

   // coordinate order: one, eye, en, eye_en
   localparam int C_O = 0;
   localparam int C_I = 1;
   localparam int C_N = 2;
   localparam int C_M = 3;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [WordWidth-1:0]  word_type;
   typedef logic signed [QuartWidth-1:0] quart_type;
   typedef logic        [NormWidth-1:0]  norm_type;

   typedef coord_type coord_vec_type [NumCoords];
   typedef prod_type  prod_mat_type  [NumCoords][NumCoords];
   typedef word_type  word_vec_type  [NumCoords];

   // ring coordinates plus the two quartic forms of the norm
   typedef struct {
      word_vec_type r;
      quart_type    x;
      quart_type    y;
   } combine_type;

   function automatic word_type ext_prod(prod_type v);
      return word_type'(v);
   endfunction

   function automatic word_type ext_coord(coord_type v);
      return word_type'(v);
   endfunction

endpackage

/* src/cra_if.sv */
// Request and response channel interfaces for the cyclotomic ring ALU.
interface cra_req_if;
   logic                valid;
   logic                ready;
   logic [2:0]          command;
   cra_pkg::coord_type  a_one;
   cra_pkg::coord_type  a_eye;
   cra_pkg::coord_type  a_en;
   cra_pkg::coord_type  a_eye_en;
   cra_pkg::coord_type  b_one;
   cra_pkg::coord_type  b_eye;
   cra_pkg::coord_type  b_en;
   cra_pkg::coord_type  b_eye_en;
   cra_pkg::coord_type  scale_factor;

   modport source (output valid, command, a_one, a_eye, a_en, a_eye_en,
                   b_one, b_eye, b_en, b_eye_en, scale_factor, input ready);
   modport sink   (input valid, command, a_one, a_eye, a_en, a_eye_en,
                   b_one, b_eye, b_en, b_eye_en, scale_factor, output ready);
endinterface

interface cra_rsp_if;
   logic               valid;
   logic               ready;
   cra_pkg::word_type  r_one;
   cra_pkg::word_type  r_eye;
   cra_pkg::word_type  r_en;
   cra_pkg::word_type  r_eye_en;
   cra_pkg::norm_type  norm_value;

   modport source (output valid, r_one, r_eye, r_en, r_eye_en, norm_value,
                   input ready);
   modport sink   (input valid, r_one, r_eye, r_en, r_eye_en, norm_value,
                   output ready);
endinterface

/* src/cra_combine.sv */
// Linear combination of partial products into ring coordinates or norm forms.
module cra_combine (
   input  logic [2:0]             command,
   input  cra_pkg::coord_vec_type a,
   input  cra_pkg::coord_vec_type b,
   input  cra_pkg::prod_mat_type  p,
   output cra_pkg::combine_type   result
);

   localparam int O = cra_pkg::C_O;
   localparam int I = cra_pkg::C_I;
   localparam int N = cra_pkg::C_N;
   localparam int M = cra_pkg::C_M;

   cra_pkg::word_type q [cra_pkg::NumCoords][cra_pkg::NumCoords];
   cra_pkg::word_type ea [cra_pkg::NumCoords];
   cra_pkg::word_type eb [cra_pkg::NumCoords];
   cra_pkg::word_type x_full;
   cra_pkg::word_type y_full;

   always_comb begin
      for (int j = 0; j < cra_pkg::NumCoords; j++) begin
         ea[j] = cra_pkg::ext_coord(a[j]);
         eb[j] = cra_pkg::ext_coord(b[j]);
         for (int k = 0; k < cra_pkg::NumCoords; k++) begin
            q[j][k] = cra_pkg::ext_prod(p[j][k]);
         end
      end
   end

   // p[j][k] = a[j] * a[k] for norm
   assign x_full = q[O][O] + q[O][N] - (q[O][M] <<< 1) - q[I][I] - (q[I][N] <<< 1)
                   - q[I][M] - (q[N][M] <<< 1);
   assign y_full = (q[O][I] <<< 1) + (q[O][N] <<< 1) + q[O][M] + q[I][N]
                   - (q[I][M] <<< 1) + q[N][N] - q[M][M];

   always_comb begin
      for (int j = 0; j < cra_pkg::NumCoords; j++) begin
         result.r[j] = '0;
      end
      result.x = '0;
      result.y = '0;
      case (command)
         cra_pkg::CMD_ADD: begin
            for (int j = 0; j < cra_pkg::NumCoords; j++) begin
               result.r[j] = ea[j] + eb[j];
            end
         end
         cra_pkg::CMD_SUB: begin
            for (int j = 0; j < cra_pkg::NumCoords; j++) begin
               result.r[j] = ea[j] - eb[j];
            end
         end
         cra_pkg::CMD_MUL: begin
            result.r[O] = q[O][O] - q[I][I] + q[M][N] + q[N][M];
            result.r[I] = q[I][O] + q[O][I] - q[N][N] + q[M][M];
            result.r[N] = q[N][O] + q[O][N] - q[M][I] - q[I][M] + q[N][N] - q[M][M]
                          - (q[M][N] <<< 1) - (q[N][M] <<< 1);
            result.r[M] = q[I][N] + q[N][I] + q[O][M] + q[M][O] + (q[N][N] <<< 1)
                          - (q[M][M] <<< 1) + q[M][N] + q[N][M];
         end
         cra_pkg::CMD_SCALE: begin
            for (int j = 0; j < cra_pkg::NumCoords; j++) begin
               result.r[j] = q[j][O];
            end
         end
         cra_pkg::CMD_CONJ: begin
            result.r[O] = ea[O] + ea[N];
            result.r[I] = -ea[I] - ea[M];
            result.r[N] = -ea[N];
            result.r[M] = ea[M];
         end
         cra_pkg::CMD_CONJ_NM: begin
            result.r[O] = ea[O] + ea[N] - (ea[M] <<< 1);
            result.r[I] = ea[I] + (ea[N] <<< 1) + ea[M];
            result.r[N] = -ea[N];
            result.r[M] = -ea[M];
         end
         cra_pkg::CMD_NORM: begin
            result.x = x_full[cra_pkg::QuartWidth-1:0];
            result.y = y_full[cra_pkg::QuartWidth-1:0];
         end
         default: begin
         end
      endcase
   end

endmodule

/* src/cyclotomic_ring_alu.sv */
// Top level: four-stage pipelined arithmetic unit for the twelfth cyclotomic ring.
// Requests pass stage registers 1 to 4, one per cycle unless the response stalls.
// Stages are a 4x4 array of 12x12 multipliers,
// the coordinate/quartic-form adder trees, two 28x28 squarers, and the norm add.
// A stalled response holds the output stage; earlier empty stages keep filling.
// Reset clears the stage valid bits only; data registers are not reset.
module cyclotomic_ring_alu (
   input  logic      clock,
   input  logic      reset,
   cra_req_if.sink   req_bus,
   cra_rsp_if.source rsp_bus
);

   localparam int NC = cra_pkg::NumCoords;

   // stage handshake
   logic s1_ready, s2_ready, s3_ready, s4_ready;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;

   assign s4_ready = !s4_valid_ff || rsp_bus.ready;
   assign s3_ready = !s3_valid_ff || s4_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   // stage 0: operand select for the shared multiplier array
   cra_pkg::coord_vec_type a_in, b_in, m_in;
   cra_pkg::prod_mat_type  p_in;

   always_comb begin
      a_in[cra_pkg::C_O] = req_bus.a_one;
      a_in[cra_pkg::C_I] = req_bus.a_eye;
      a_in[cra_pkg::C_N] = req_bus.a_en;
      a_in[cra_pkg::C_M] = req_bus.a_eye_en;
      b_in[cra_pkg::C_O] = req_bus.b_one;
      b_in[cra_pkg::C_I] = req_bus.b_eye;
      b_in[cra_pkg::C_N] = req_bus.b_en;
      b_in[cra_pkg::C_M] = req_bus.b_eye_en;
      for (int k = 0; k < NC; k++) begin
         case (req_bus.command)
            cra_pkg::CMD_NORM:  m_in[k] = a_in[k];
            cra_pkg::CMD_SCALE: m_in[k] = req_bus.scale_factor;
            default:            m_in[k] = b_in[k];
         endcase
      end
      for (int j = 0; j < NC; j++) begin
         for (int k = 0; k < NC; k++) begin
            p_in[j][k] = a_in[j] * m_in[k];
         end
      end
   end

   // stage 1 registers: products and operands
   logic [2:0]             s1_cmd_ff;
   cra_pkg::coord_vec_type s1_a_ff, s1_b_ff;
   cra_pkg::prod_mat_type  s1_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (s1_ready) begin
         s1_cmd_ff <= req_bus.command;
         s1_a_ff   <= a_in;
         s1_b_ff   <= b_in;
         s1_p_ff   <= p_in;
      end
   end

   // stage 2: linear combination
   cra_pkg::combine_type s2_in;
   cra_pkg::combine_type s2_ff;

   cra_combine u_combine (
      .command (s1_cmd_ff),
      .a       (s1_a_ff),
      .b       (s1_b_ff),
      .p       (s1_p_ff),
      .result  (s2_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_ready) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: squares of the quartic forms
   logic signed [2*cra_pkg::QuartWidth-1:0] xsq_in, ysq_in;
   cra_pkg::word_vec_type s3_r_ff;
   cra_pkg::norm_type     s3_xsq_ff, s3_ysq_ff;

   assign xsq_in = s2_ff.x * s2_ff.x;
   assign ysq_in = s2_ff.y * s2_ff.y;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (s3_ready) begin
         s3_r_ff   <= s2_ff.r;
         s3_xsq_ff <= xsq_in[cra_pkg::NormWidth-1:0];
         s3_ysq_ff <= ysq_in[cra_pkg::NormWidth-1:0];
      end
   end

   // stage 4: norm sum, output register
   cra_pkg::word_vec_type s4_r_ff;
   cra_pkg::norm_type     s4_norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s4_ready) begin
         s4_r_ff    <= s3_r_ff;
         s4_norm_ff <= s3_xsq_ff + s3_ysq_ff;
      end
   end

   assign rsp_bus.valid      = s4_valid_ff;
   assign rsp_bus.r_one      = s4_r_ff[cra_pkg::C_O];
   assign rsp_bus.r_eye      = s4_r_ff[cra_pkg::C_I];
   assign rsp_bus.r_en       = s4_r_ff[cra_pkg::C_N];
   assign rsp_bus.r_eye_en   = s4_r_ff[cra_pkg::C_M];
   assign rsp_bus.norm_value = s4_norm_ff;

   // norm responses carry no ring coordinates
   a_norm_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.norm_value != '0 |->
         rsp_bus.r_one == '0 && rsp_bus.r_eye == '0 &&
         rsp_bus.r_en == '0 && rsp_bus.r_eye_en == '0)
      else $error("norm response with nonzero ring coordinates");

   // quartic forms are zero outside the norm command
   a_forms_zero: assert property (@(posedge clock) disable iff (reset)
      s1_cmd_ff != cra_pkg::CMD_NORM |-> s2_in.x == '0 && s2_in.y == '0)
      else $error("quartic forms nonzero for a non-norm request");

   // backpressure only when every stage is full
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |->
         s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && !rsp_bus.ready)
      else $error("request stalled with a bubble in the pipeline");

endmodule
